// ===== rtl/psl_pkg.sv =====
`default_nettype none
package psl_pkg;

  // Sizes of the list and of the item fields.
  localparam int unsigned CAPACITY      = 64;
  localparam int unsigned PAYLOAD_WIDTH = 64;
  localparam int unsigned ADDR_W        = $clog2(CAPACITY);
  localparam int unsigned OP_W          = 3;
  localparam int unsigned POS_W         = 7;
  localparam int unsigned LEN_W         = 7;
  localparam int unsigned KEY_W         = 64;
  localparam int unsigned DATA_W        = 64;
  localparam int unsigned STATUS_W      = 2;

  // Command queue between the front and the engine.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_GET    = 3'd2,
    OP_LOCATE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CMD_INSERT,
    CMD_DELETE,
    CMD_GET,
    CMD_LOCATE,
    CMD_CLEAR,
    CMD_NOP
  } cmd_e;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_SHIFT_UP,
    ENG_SHIFT_DOWN,
    ENG_GET,
    ENG_SCAN
  } eng_state_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  position;
    logic [KEY_W-1:0]  entry_key;
    logic [DATA_W-1:0] entry_payload;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    found_position;
    logic [KEY_W-1:0]    read_key;
    logic [DATA_W-1:0]   read_payload;
    logic [LEN_W-1:0]    list_length;
  } rsp_t;

  typedef struct packed {
    cmd_e                     kind;
    logic [POS_W-1:0]         position;
    logic [KEY_W-1:0]         key;
    logic [PAYLOAD_WIDTH-1:0] payload;
  } job_t;

endpackage
`default_nettype wire

// ===== rtl/psl_if.sv =====
`default_nettype none
interface psl_cmd_if;
  logic            valid;
  logic            ready;
  psl_pkg::cmd_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface psl_rsp_if;
  logic            valid;
  logic            ready;
  psl_pkg::rsp_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/psl_front.sv =====
`default_nettype none
module psl_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  psl_cmd_if.sink            cmd_i,
  output psl_pkg::job_t      job_o,
  output logic               job_valid_o,
  input  wire logic          job_ready_i
);

  logic          slot_valid_q, slot_valid_d;
  psl_pkg::job_t slot_q;
  psl_pkg::job_t job_d;
  logic          take;

  assign cmd_i.ready = !slot_valid_q || job_ready_i;
  assign take        = cmd_i.valid && cmd_i.ready;

  // Op codes without a meaning become a no-op that only reports the length.
  always_comb begin
    job_d.position = cmd_i.data.position;
    job_d.key      = cmd_i.data.entry_key;
    job_d.payload  = cmd_i.data.entry_payload[psl_pkg::PAYLOAD_WIDTH-1:0];
    case (cmd_i.data.op)
      psl_pkg::OP_INSERT: job_d.kind = psl_pkg::CMD_INSERT;
      psl_pkg::OP_DELETE: job_d.kind = psl_pkg::CMD_DELETE;
      psl_pkg::OP_GET:    job_d.kind = psl_pkg::CMD_GET;
      psl_pkg::OP_LOCATE: job_d.kind = psl_pkg::CMD_LOCATE;
      psl_pkg::OP_CLEAR:  job_d.kind = psl_pkg::CMD_CLEAR;
      default:            job_d.kind = psl_pkg::CMD_NOP;
    endcase
  end

  always_comb begin
    slot_valid_d = slot_valid_q;
    if (take) begin
      slot_valid_d = 1'b1;
    end else if (job_ready_i) begin
      slot_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= 1'b0;
    end else begin
      slot_valid_q <= slot_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      slot_q <= job_d;
    end
  end

  assign job_o       = slot_q;
  assign job_valid_o = slot_valid_q;

endmodule
`default_nettype wire

// ===== rtl/psl_queue.sv =====
`default_nettype none
module psl_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  psl_pkg::job_t      push_data_i,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output psl_pkg::job_t      pop_data_o
);

  psl_pkg::job_t                 entry_q [psl_pkg::QUEUE_DEPTH];
  logic [psl_pkg::Q_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [psl_pkg::Q_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [psl_pkg::Q_CNT_W-1:0]   fill_q, fill_d;
  logic                          push, pop;

  assign push_ready_o = fill_q != psl_pkg::Q_CNT_W'(psl_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = fill_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == psl_pkg::Q_PTR_W'(psl_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == psl_pkg::Q_PTR_W'(psl_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/psl_engine.sv =====
`default_nettype none
module psl_engine (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     job_valid_i,
  output logic                          job_ready_o,
  input  psl_pkg::job_t                 job_i,
  psl_rsp_if.source                     rsp_o,
  output logic [psl_pkg::LEN_W-1:0]     count_o
);

  localparam int unsigned AW = psl_pkg::ADDR_W;
  localparam int unsigned LW = psl_pkg::LEN_W;
  localparam int unsigned PW = psl_pkg::PAYLOAD_WIDTH;

  // Entry storage: one write and one registered read per cycle.
  logic [psl_pkg::KEY_W-1:0] key_mem_q [psl_pkg::CAPACITY];
  logic [PW-1:0]             pay_mem_q [psl_pkg::CAPACITY];
  logic [psl_pkg::KEY_W-1:0] rd_key_q;
  logic [PW-1:0]             rd_pay_q;

  psl_pkg::eng_state_e state_q, state_d;
  psl_pkg::job_t       job_q;
  logic [LW-1:0]       count_q, count_d;
  logic [AW-1:0]       rd_idx_q, rd_idx_d;
  logic [AW-1:0]       wr_idx_q, wr_idx_d;
  logic [LW-1:0]       left_q, left_d;
  logic                pend_q, pend_d;
  logic                rsp_valid_q, rsp_valid_d;
  psl_pkg::rsp_t       rsp_q, rsp_d;

  logic                      take;
  logic                      ins_ok, del_ok, full, issue, hit, drained;
  logic                      mem_we;
  logic [AW-1:0]             waddr, raddr;
  logic [psl_pkg::KEY_W-1:0] wkey;
  logic [PW-1:0]             wpay;

  assign job_ready_o = (state_q == psl_pkg::ENG_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign take        = job_valid_i && job_ready_o;

  assign ins_ok  = (job_i.position != '0) && (job_i.position <= count_q + LW'(1));
  assign del_ok  = (job_i.position != '0) && (job_i.position <= count_q);
  assign full    = count_q == LW'(psl_pkg::CAPACITY);
  assign issue   = left_q != '0;
  assign drained = !issue && !pend_q;
  assign hit     = pend_q && (rd_key_q == job_q.key);

  always_comb begin
    state_d = state_q;
    case (state_q)
      psl_pkg::ENG_IDLE: begin
        if (take) begin
          case (job_i.kind)
            psl_pkg::CMD_INSERT: begin
              if (ins_ok && !full) begin
                state_d = psl_pkg::ENG_SHIFT_UP;
              end
            end
            psl_pkg::CMD_DELETE: begin
              if (del_ok) begin
                state_d = psl_pkg::ENG_SHIFT_DOWN;
              end
            end
            psl_pkg::CMD_GET: begin
              if (del_ok) begin
                state_d = psl_pkg::ENG_GET;
              end
            end
            psl_pkg::CMD_LOCATE: state_d = psl_pkg::ENG_SCAN;
            default:             state_d = psl_pkg::ENG_IDLE;
          endcase
        end
      end
      psl_pkg::ENG_SHIFT_UP,
      psl_pkg::ENG_SHIFT_DOWN: begin
        if (drained) begin
          state_d = psl_pkg::ENG_IDLE;
        end
      end
      psl_pkg::ENG_GET: state_d = psl_pkg::ENG_IDLE;
      psl_pkg::ENG_SCAN: begin
        if (hit || drained) begin
          state_d = psl_pkg::ENG_IDLE;
        end
      end
      default: state_d = psl_pkg::ENG_IDLE;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    left_d      = left_q;
    pend_d      = 1'b0;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_d       = rsp_q;
    mem_we      = 1'b0;
    waddr       = wr_idx_q;
    wkey        = rd_key_q;
    wpay        = rd_pay_q;
    raddr       = rd_idx_q;

    case (state_q)
      psl_pkg::ENG_IDLE: begin
        // A get reads its entry while the command is taken.
        raddr = AW'(job_i.position - psl_pkg::POS_W'(1));
        if (take) begin
          rsp_d                = '0;
          rsp_d.list_length    = count_q;
          case (job_i.kind)
            psl_pkg::CMD_INSERT: begin
              rd_idx_d = AW'(count_q - LW'(1));
              left_d   = count_q - job_i.position + LW'(1);
              if (!ins_ok) begin
                rsp_valid_d  = 1'b1;
                rsp_d.status = psl_pkg::ST_BAD_POS;
              end else if (full) begin
                rsp_valid_d  = 1'b1;
                rsp_d.status = psl_pkg::ST_FULL;
              end
            end
            psl_pkg::CMD_DELETE: begin
              rd_idx_d = AW'(job_i.position);
              left_d   = count_q - job_i.position;
              if (!del_ok) begin
                rsp_valid_d  = 1'b1;
                rsp_d.status = psl_pkg::ST_BAD_POS;
              end
            end
            psl_pkg::CMD_GET: begin
              if (!del_ok) begin
                rsp_valid_d  = 1'b1;
                rsp_d.status = psl_pkg::ST_BAD_POS;
              end
            end
            psl_pkg::CMD_LOCATE: begin
              rd_idx_d = '0;
              left_d   = count_q;
            end
            psl_pkg::CMD_CLEAR: begin
              count_d           = '0;
              rsp_valid_d       = 1'b1;
              rsp_d.list_length = '0;
            end
            default: begin
              rsp_valid_d = 1'b1;
            end
          endcase
        end
      end

      psl_pkg::ENG_SHIFT_UP: begin
        // Walk down from the last entry, each one written a slot higher
        // in the cycle after its read.
        if (issue) begin
          rd_idx_d = rd_idx_q - 1'b1;
          wr_idx_d = rd_idx_q + 1'b1;
          left_d   = left_q - 1'b1;
          pend_d   = 1'b1;
        end
        if (pend_q) begin
          mem_we = 1'b1;
        end else if (!issue) begin
          mem_we            = 1'b1;
          waddr             = AW'(job_q.position - psl_pkg::POS_W'(1));
          wkey              = job_q.key;
          wpay              = job_q.payload;
          count_d           = count_q + LW'(1);
          rsp_valid_d       = 1'b1;
          rsp_d             = '0;
          rsp_d.list_length = count_q + LW'(1);
        end
      end

      psl_pkg::ENG_SHIFT_DOWN: begin
        if (issue) begin
          rd_idx_d = rd_idx_q + 1'b1;
          wr_idx_d = rd_idx_q - 1'b1;
          left_d   = left_q - 1'b1;
          pend_d   = 1'b1;
        end
        if (pend_q) begin
          mem_we = 1'b1;
        end else if (!issue) begin
          count_d           = count_q - LW'(1);
          rsp_valid_d       = 1'b1;
          rsp_d             = '0;
          rsp_d.list_length = count_q - LW'(1);
        end
      end

      psl_pkg::ENG_GET: begin
        rsp_valid_d        = 1'b1;
        rsp_d              = '0;
        rsp_d.read_key     = rd_key_q;
        rsp_d.read_payload = psl_pkg::DATA_W'(rd_pay_q);
        rsp_d.list_length  = count_q;
      end

      psl_pkg::ENG_SCAN: begin
        // wr_idx_q names the entry whose key is compared this cycle.
        if (issue) begin
          rd_idx_d = rd_idx_q + 1'b1;
          wr_idx_d = rd_idx_q;
          left_d   = left_q - 1'b1;
          pend_d   = 1'b1;
        end
        if (hit) begin
          rsp_valid_d          = 1'b1;
          rsp_d                = '0;
          rsp_d.found_position = psl_pkg::POS_W'(wr_idx_q) + psl_pkg::POS_W'(1);
          rsp_d.read_key       = rd_key_q;
          rsp_d.read_payload   = psl_pkg::DATA_W'(rd_pay_q);
          rsp_d.list_length    = count_q;
        end else if (drained) begin
          rsp_valid_d       = 1'b1;
          rsp_d             = '0;
          rsp_d.status      = psl_pkg::ST_NOT_FOUND;
          rsp_d.list_length = count_q;
        end
      end

      default: begin
        rsp_valid_d = rsp_valid_q && !rsp_o.ready;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psl_pkg::ENG_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      left_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      left_q      <= left_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    wr_idx_q <= wr_idx_d;
    rsp_q    <= rsp_d;
    if (take) begin
      job_q <= job_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem_q[waddr] <= wkey;
      pay_mem_q[waddr] <= wpay;
    end
    rd_key_q <= key_mem_q[raddr];
    rd_pay_q <= pay_mem_q[raddr];
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;
  assign count_o     = count_q;

endmodule
`default_nettype wire

// ===== rtl/positional_sequential_list_top.sv =====
`default_nettype none
// Ordered list of up to 64 entries (64-bit key, 64-bit payload), one-based
// positions, driven by insert, delete, get, locate and clear commands with one
// response per command carrying the length after it. Commands pass a register
// stage and a two-entry queue, so up to three items wait ahead of the engine
// before the input stalls. The engine owns a single-port-write, registered-read
// entry memory and moves one entry per cycle through it. It takes no new
// command until the current one is done: on a list of n entries, an insert at
// position p shifts entries p to n up by one slot, a delete shifts the entries
// after p down by one, a locate reads entries from the first until a key
// matches or the list ends, and a get reads its one entry; a clear, a rejected
// command or an unused op code needs no memory walk. Sustained throughput is
// set by that memory walk; a response that is not taken holds the engine. No
// clearing pass is needed after reset.
module positional_sequential_list_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  psl_cmd_if.sink     cmd_i,
  psl_rsp_if.source   rsp_o
);

  psl_pkg::job_t                front_job, queue_job;
  logic                         front_valid, front_ready;
  logic                         queue_valid, queue_ready;
  logic [psl_pkg::LEN_W-1:0]    count;

  psl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .job_o       (front_job),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready)
  );

  psl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_job),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_data_o   (queue_job)
  );

  psl_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (queue_valid),
    .job_ready_o (queue_ready),
    .job_i       (queue_job),
    .rsp_o       (rsp_o),
    .count_o     (count)
  );

  // The length moves by one at most, or drops to zero on a clear.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count != $past(count)) |->
      (count == $past(count) + psl_pkg::LEN_W'(1)) ||
      (count == $past(count) - psl_pkg::LEN_W'(1)) ||
      (count == '0))
    else $error("list length changed by more than one entry");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= psl_pkg::LEN_W'(psl_pkg::CAPACITY))
    else $error("list length above capacity");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.data.found_position != '0)) |->
      (rsp_o.data.status == psl_pkg::ST_OK))
    else $error("match position reported with a failing status");

  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.data.status == psl_pkg::ST_NOT_FOUND)) |->
      ((rsp_o.data.found_position == '0) && (rsp_o.data.read_key == '0) &&
       (rsp_o.data.read_payload == '0)))
    else $error("locate miss carries entry data");

endmodule
`default_nettype wire

// ===== bench/positional_sequential_list_top_tb.sv =====
`default_nettype none
module positional_sequential_list_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS = 850;
  localparam int HOLD_AT = 300;
  localparam int LONG_HOLD = 400;
  localparam int TAIL_CYCLES = 150;
  localparam int FULL_BUILDS = 3;
  localparam logic [psl_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [psl_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;
  localparam logic [psl_pkg::KEY_W-1:0] ALL_ONES = {psl_pkg::KEY_W{1'b1}};

  typedef enum {RX_STEADY, RX_HALF, RX_MOSTLY, RX_PERIODIC} rx_mode_e;

  typedef struct {
    psl_pkg::cmd_t cmd;
    bit            wait_drained;
  } pending_t;

  logic clk_i;
  logic rst_ni;

  psl_cmd_if cmd_if ();
  psl_rsp_if rsp_if ();

  positional_sequential_list_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  pending_t      command_q[$];
  psl_pkg::rsp_t expected_rsp_q[$];
  int            accepted_n = 0;
  int            received_n = 0;
  int            mismatches = 0;

  // Predicted contents of the list.
  logic [psl_pkg::KEY_W-1:0]         list_keys     [psl_pkg::CAPACITY];
  logic [psl_pkg::PAYLOAD_WIDTH-1:0] list_payloads [psl_pkg::CAPACITY];
  int                                list_len = 0;

  int n_insert = 0, n_delete = 0, n_get = 0, n_locate = 0, n_clear = 0, n_spare = 0;
  int n_bad_pos = 0, n_full = 0, n_hit = 0, n_miss = 0, peak_len = 0;

  function automatic psl_pkg::rsp_t apply_command(psl_pkg::cmd_t c);
    psl_pkg::rsp_t r;
    int            p;
    int            j;
    r = '0;
    p = int'(c.position);
    case (c.op)
      psl_pkg::OP_INSERT: begin
        n_insert++;
        if (p < 1 || p > list_len + 1) begin
          r.status = psl_pkg::ST_BAD_POS;
          n_bad_pos++;
        end else if (list_len >= psl_pkg::CAPACITY) begin
          r.status = psl_pkg::ST_FULL;
          n_full++;
        end else begin
          for (j = list_len; j >= p; j--) begin
            list_keys[j]     = list_keys[j-1];
            list_payloads[j] = list_payloads[j-1];
          end
          list_keys[p-1]     = c.entry_key;
          list_payloads[p-1] = c.entry_payload[psl_pkg::PAYLOAD_WIDTH-1:0];
          list_len++;
          if (list_len > peak_len) peak_len = list_len;
        end
      end
      psl_pkg::OP_DELETE: begin
        n_delete++;
        if (p < 1 || p > list_len) begin
          r.status = psl_pkg::ST_BAD_POS;
          n_bad_pos++;
        end else begin
          for (j = p; j < list_len; j++) begin
            list_keys[j-1]     = list_keys[j];
            list_payloads[j-1] = list_payloads[j];
          end
          list_len--;
        end
      end
      psl_pkg::OP_GET: begin
        n_get++;
        if (p < 1 || p > list_len) begin
          r.status = psl_pkg::ST_BAD_POS;
          n_bad_pos++;
        end else begin
          r.read_key     = list_keys[p-1];
          r.read_payload = psl_pkg::DATA_W'(list_payloads[p-1]);
        end
      end
      psl_pkg::OP_LOCATE: begin
        n_locate++;
        r.status = psl_pkg::ST_NOT_FOUND;
        for (j = 0; j < list_len; j++) begin
          if (list_keys[j] == c.entry_key) begin
            r.status         = psl_pkg::ST_OK;
            r.found_position = psl_pkg::POS_W'(j + 1);
            r.read_key       = list_keys[j];
            r.read_payload   = psl_pkg::DATA_W'(list_payloads[j]);
            break;
          end
        end
        if (r.status == psl_pkg::ST_OK) n_hit++;
        else n_miss++;
      end
      psl_pkg::OP_CLEAR: begin
        n_clear++;
        list_len = 0;
      end
      default: n_spare++;
    endcase
    r.list_length = psl_pkg::LEN_W'(list_len);
    return r;
  endfunction

  // Stimulus generation tracks only the length, to aim positions at the
  // valid range and at its edges.
  int   plan_len = 0;
  int   gen_count = 0;
  bit   hold_next = 1'b0;
  bit   drain_marked = 1'b0;
  logic [psl_pkg::KEY_W-1:0] key_pool [8];

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [psl_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(0, 1) == 0) return key_pool[$urandom_range(0, 7)];
    return rand64();
  endfunction

  // A key from the pool that is unlikely to have been the first inserted.
  function automatic logic [psl_pkg::KEY_W-1:0] list_tail_key();
    return key_pool[7];
  endfunction

  function automatic int pick_pos(bit for_insert);
    int limit;
    int r;
    limit = plan_len + int'(for_insert);
    r = $urandom_range(0, 9);
    if (limit == 0 || r == 0) return $urandom_range(0, 127);
    if (r < 3) return 1;
    if (r < 5) return limit;
    return $urandom_range(1, limit);
  endfunction

  task automatic queue_cmd(logic [psl_pkg::OP_W-1:0] op, int pos,
                           logic [psl_pkg::KEY_W-1:0] key,
                           logic [psl_pkg::DATA_W-1:0] pay);
    pending_t it;
    it.cmd.op            = op;
    it.cmd.position      = psl_pkg::POS_W'(pos);
    it.cmd.entry_key     = key;
    it.cmd.entry_payload = pay;
    it.wait_drained      = hold_next;
    hold_next = 1'b0;
    command_q.push_back(it);
    case (op)
      psl_pkg::OP_INSERT: begin
        if (pos >= 1 && pos <= plan_len + 1 && plan_len < psl_pkg::CAPACITY) plan_len++;
      end
      psl_pkg::OP_DELETE: if (pos >= 1 && pos <= plan_len) plan_len--;
      psl_pkg::OP_CLEAR:  plan_len = 0;
      default: ;
    endcase
    if (op <= psl_pkg::OP_CLEAR) gen_count++;
  endtask

  task automatic random_mix(int n);
    int i;
    int w;
    for (i = 0; i < n; i++) begin
      w = $urandom_range(0, 99);
      if (w < 30) queue_cmd(psl_pkg::OP_INSERT, pick_pos(1'b1), pick_key(), rand64());
      else if (w < 50) queue_cmd(psl_pkg::OP_DELETE, pick_pos(1'b0), rand64(), rand64());
      else if (w < 70) queue_cmd(psl_pkg::OP_GET, pick_pos(1'b0), rand64(), rand64());
      else if (w < 95) queue_cmd(psl_pkg::OP_LOCATE, $urandom_range(0, 127), pick_key(),
                                 rand64());
      else if (w < 97) queue_cmd(psl_pkg::OP_CLEAR, $urandom_range(0, 127), rand64(),
                                 rand64());
      else queue_cmd(psl_pkg::OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                     $urandom_range(0, 127), rand64(), rand64());
    end
  endtask

  task automatic build_list(int target);
    int i;
    while (plan_len < target)
      queue_cmd(psl_pkg::OP_INSERT, $urandom_range(1, plan_len + 1), pick_key(), rand64());
    if (plan_len == psl_pkg::CAPACITY) begin
      // A valid position on a full list is refused as full, a bad one as a
      // bad position.
      for (i = 0; i < 3; i++)
        queue_cmd(psl_pkg::OP_INSERT, $urandom_range(1, plan_len + 1), pick_key(),
                  rand64());
      queue_cmd(psl_pkg::OP_INSERT, $urandom_range(plan_len + 2, 127), pick_key(),
                rand64());
      queue_cmd(psl_pkg::OP_INSERT, 0, pick_key(), rand64());
      queue_cmd(psl_pkg::OP_LOCATE, 0, list_tail_key(), rand64());
      random_mix($urandom_range(6, 12));
      queue_cmd(psl_pkg::OP_CLEAR, 0, rand64(), rand64());
    end else begin
      random_mix($urandom_range(8, 20));
    end
  endtask

  task automatic make_stimulus();
    logic [psl_pkg::KEY_W-1:0] k;
    int i;
    int full_runs;
    k = rand64();
    key_pool[0] = '0;
    key_pool[1] = ALL_ONES;
    for (i = 2; i < 8; i++) key_pool[i] = rand64();

    queue_cmd(psl_pkg::OP_CLEAR, 0, '0, '0);
    queue_cmd(psl_pkg::OP_GET, 1, '0, '0);
    queue_cmd(psl_pkg::OP_DELETE, 1, '0, '0);
    queue_cmd(psl_pkg::OP_LOCATE, 0, '0, '0);
    queue_cmd(psl_pkg::OP_INSERT, 0, k, rand64());
    queue_cmd(psl_pkg::OP_INSERT, 2, k, rand64());
    queue_cmd(psl_pkg::OP_INSERT, 1, ALL_ONES, ALL_ONES);
    queue_cmd(psl_pkg::OP_INSERT, 1, '0, '0);
    queue_cmd(psl_pkg::OP_INSERT, 3, k, rand64());
    queue_cmd(psl_pkg::OP_INSERT, 2, ALL_ONES, rand64());
    queue_cmd(psl_pkg::OP_LOCATE, 127, ALL_ONES, '0);
    queue_cmd(psl_pkg::OP_LOCATE, 0, '0, ALL_ONES);
    queue_cmd(psl_pkg::OP_LOCATE, 0, ~k, '0);
    queue_cmd(psl_pkg::OP_GET, 4, '0, '0);
    queue_cmd(psl_pkg::OP_GET, 5, ALL_ONES, ALL_ONES);
    queue_cmd(psl_pkg::OP_GET, 127, '0, '0);
    queue_cmd(psl_pkg::OP_DELETE, 5, '0, '0);
    queue_cmd(psl_pkg::OP_DELETE, 2, '0, '0);
    queue_cmd(psl_pkg::OP_GET, 2, '0, '0);
    for (i = 5; i <= 7; i++)
      queue_cmd(psl_pkg::OP_W'(i), $urandom_range(0, 127), rand64(), rand64());
    queue_cmd(psl_pkg::OP_DELETE, 3, '0, '0);
    queue_cmd(psl_pkg::OP_CLEAR, 127, ALL_ONES, ALL_ONES);
    queue_cmd(psl_pkg::OP_GET, 1, '0, '0);

    build_list(psl_pkg::CAPACITY);
    full_runs = 1;
    while (gen_count < ITEMS) begin
      if (gen_count > ITEMS / 2 && !drain_marked) begin
        hold_next    = 1'b1;
        drain_marked = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          if (full_runs < FULL_BUILDS && $urandom_range(0, 5) == 0) begin
            full_runs++;
            build_list(psl_pkg::CAPACITY);
          end else begin
            build_list($urandom_range(1, 16));
          end
        end
        9: begin
          i = $urandom_range(0, 4);
          while (plan_len > i)
            queue_cmd(psl_pkg::OP_DELETE, $urandom_range(1, plan_len), rand64(), rand64());
          if ($urandom_range(0, 1) == 0)
            queue_cmd(psl_pkg::OP_CLEAR, 0, rand64(), rand64());
        end
        default: random_mix($urandom_range(10, 30));
      endcase
    end
  endtask

  // Sender: bursts of items separated by idle gaps.
  int gap_left = 0;
  int burst_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin : drive_items
    bit       took;
    int       pending;
    int       r;
    pending_t it;
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
    end else begin
      took = cmd_if.valid && cmd_if.ready;
      if (took) begin
        expected_rsp_q.push_back(apply_command(cmd_if.data));
        accepted_n <= accepted_n + 1;
      end
      if (!cmd_if.valid || took) begin
        pending = accepted_n + int'(took) - received_n;
        if (gap_left > 0) begin
          gap_left--;
          cmd_if.valid <= 1'b0;
        end else if (command_q.size() > 0 &&
                     (!command_q[0].wait_drained || pending == 0)) begin
          it = command_q.pop_front();
          cmd_if.data  <= it.cmd;
          cmd_if.valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            r = $urandom_range(0, 9);
            if (r < 3) begin
              burst_left = $urandom_range(50, 150);
              gap_left   = 0;
            end else if (r < 8) begin
              burst_left = $urandom_range(1, 20);
              gap_left   = $urandom_range(1, 6);
            end else begin
              burst_left = $urandom_range(1, 10);
              gap_left   = $urandom_range(10, 30);
            end
          end
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: ready follows a mode that changes every so often, with one long
  // hold-off so that the block backs up into its input.
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  int       phase_left = 0;
  int       rx_tick = 0;
  rx_mode_e rx_mode = RX_STEADY;

  always @(posedge clk_i or negedge rst_ni) begin : drive_ready
    bit ready_next;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rx_tick++;
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (!hold_done && received_n >= HOLD_AT) begin
        hold_done  = 1'b1;
        hold_left  = LONG_HOLD;
        ready_next = 1'b0;
      end else begin
        if (phase_left == 0) begin
          rx_mode    = rx_mode_e'($urandom_range(0, 3));
          phase_left = $urandom_range(20, 200);
        end
        phase_left--;
        case (rx_mode)
          RX_HALF:     ready_next = $urandom_range(0, 1) == 0;
          RX_MOSTLY:   ready_next = $urandom_range(0, 6) != 0;
          RX_PERIODIC: ready_next = (rx_tick % 7) >= 3;
          default:     ready_next = 1'b1;
        endcase
      end
      rsp_if.ready <= ready_next;
    end
  end

  task automatic note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  task automatic compare_field(string name, int idx, logic [63:0] want, logic [63:0] got);
    if (want !== got)
      note_failure($sformatf("result %0d %s: expected %0h, got %0h", idx, name, want, got));
  endtask

  always @(posedge clk_i) begin : check_results
    psl_pkg::rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (received_n >= accepted_n) begin
        note_failure($sformatf("unexpected result after %0d results: %p", received_n,
                               rsp_if.data));
      end else begin
        want = expected_rsp_q.pop_front();
        compare_field("status", received_n, 64'(want.status), 64'(rsp_if.data.status));
        compare_field("found_position", received_n, 64'(want.found_position),
                      64'(rsp_if.data.found_position));
        compare_field("read_key", received_n, want.read_key, rsp_if.data.read_key);
        compare_field("read_payload", received_n, want.read_payload,
                      rsp_if.data.read_payload);
        compare_field("list_length", received_n, 64'(want.list_length),
                      64'(rsp_if.data.list_length));
        received_n <= received_n + 1;
      end
    end
  end

  initial begin : watchdog
    #12_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin : run_test
    rst_ni        = 1'b0;
    cmd_if.valid  = 1'b0;
    cmd_if.data   = '0;
    rsp_if.ready  = 1'b0;
    make_stimulus();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (command_q.size() != 0 || cmd_if.valid) @(posedge clk_i);
    while (received_n != accepted_n) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_rsp_q.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_rsp_q.size()));
    $display("Ran %0d commands: %0d insert, %0d delete, %0d get, %0d locate,",
             accepted_n, n_insert, n_delete, n_get, n_locate);
    $display("%0d clear, %0d spare op; rejected %0d on position, %0d on a full list.",
             n_clear, n_spare, n_bad_pos, n_full);
    $display("Locate hit %0d, missed %0d; peak length %0d; %0d mismatches.",
             n_hit, n_miss, peak_len, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/psl_pkg.sv
rtl/psl_if.sv
rtl/psl_front.sv
rtl/psl_queue.sv
rtl/psl_engine.sv
rtl/positional_sequential_list_top.sv
bench/positional_sequential_list_top_tb.sv
